// File: hdl/tcgm_pkg.sv
`default_nettype none

package tcgm_pkg;

  // Fixed field widths of the color ramp.
  localparam int VALUE_BITS = 24;
  localparam int SPAN_BITS  = VALUE_BITS;
  localparam int QUO_BITS   = 8;
  localparam int NUM_BITS   = VALUE_BITS + QUO_BITS;
  localparam int CHANNELS   = 4;
  localparam int COLOR_BITS = 32;
  localparam int REG_IDX_BITS = 2;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_LOW_LEVEL   = 2'd0,
    REG_HIGH_LEVEL  = 2'd1,
    REG_START_COLOR = 2'd2,
    REG_END_COLOR   = 2'd3
  } reg_idx_t;

  // How a sample is colored.
  typedef enum logic [1:0] {
    CLS_INVALID,
    CLS_START,
    CLS_END,
    CLS_RAMP
  } cls_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         sample_invalid;
  } in_payload_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } out_payload_t;

  // Control that travels along the divider chain.
  typedef struct packed {
    logic valid;
    cls_t cls;
  } cell_ctl_t;

  // Data that travels along the divider chain, one lane per channel.
  typedef struct packed {
    logic [SPAN_BITS-1:0]                span;
    logic [CHANNELS-1:0][NUM_BITS-1:0]   rem;
    logic [CHANNELS-1:0][QUO_BITS-1:0]   quo;
  } div_data_t;

endpackage

`default_nettype wire

// File: hdl/tcgm_front.sv
`default_nettype none

module tcgm_front
  import tcgm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  in_payload_t      in_payload,
  input  value_t           low_level,
  input  value_t           high_level,
  input  color_t           start_color,
  input  color_t           end_color,
  output cell_ctl_t        ctl_o,
  output div_data_t        data_o
);

  logic signed [VALUE_BITS:0] v_ext;
  logic signed [VALUE_BITS:0] lo_ext;
  logic signed [VALUE_BITS:0] hi_ext;
  logic signed [VALUE_BITS:0] span_full;
  logic signed [VALUE_BITS:0] wlo_full;
  logic signed [VALUE_BITS:0] whi_full;
  cls_t                       cls_nxt;

  logic                       valid_a_r;
  cls_t                       cls_a_r;
  logic [SPAN_BITS-1:0]       span_a_r;
  logic [SPAN_BITS-1:0]       wlo_a_r;
  logic [SPAN_BITS-1:0]       whi_a_r;

  cell_ctl_t                  ctl_r;
  div_data_t                  data_r;
  div_data_t                  data_nxt;

  // Classify the sample against the levels and form the ramp weights.
  always_comb begin
    v_ext     = {in_payload.sample_value[VALUE_BITS-1], in_payload.sample_value};
    lo_ext    = {low_level[VALUE_BITS-1], low_level};
    hi_ext    = {high_level[VALUE_BITS-1], high_level};
    span_full = hi_ext - lo_ext;
    wlo_full  = hi_ext - v_ext;
    whi_full  = v_ext - lo_ext;
    if (in_payload.sample_invalid) begin
      cls_nxt = CLS_INVALID;
    end else if (v_ext <= lo_ext) begin
      cls_nxt = CLS_START;
    end else if (v_ext >= hi_ext) begin
      cls_nxt = CLS_END;
    end else begin
      cls_nxt = CLS_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= accept;
    end
    cls_a_r  <= cls_nxt;
    span_a_r <= span_full[SPAN_BITS-1:0];
    wlo_a_r  <= wlo_full[SPAN_BITS-1:0];
    whi_a_r  <= whi_full[SPAN_BITS-1:0];
  end

  // Weighted sum per channel: c0 * (high - v) + c1 * (v - low).
  always_comb begin
    data_nxt      = '0;
    data_nxt.span = span_a_r;
    for (int k = 0; k < CHANNELS; k++) begin
      data_nxt.rem[k] =
        NUM_BITS'(start_color[8*(CHANNELS-1-k) +: 8]) * NUM_BITS'(wlo_a_r) +
        NUM_BITS'(end_color[8*(CHANNELS-1-k) +: 8]) * NUM_BITS'(whi_a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= valid_a_r;
    end
    ctl_r.cls <= cls_a_r;
    data_r    <= data_nxt;
  end

  assign ctl_o  = ctl_r;
  assign data_o = data_r;

endmodule

`default_nettype wire

// File: hdl/tcgm_div_cell.sv
`default_nettype none

module tcgm_div_cell
  import tcgm_pkg::*;
#(
  parameter int BIT_POS = 0
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  cell_ctl_t ctl_i,
  input  div_data_t data_i,
  output cell_ctl_t ctl_o,
  output div_data_t data_o
);

  logic [NUM_BITS-1:0] divisor;
  div_data_t           data_nxt;
  cell_ctl_t           ctl_r;
  div_data_t           data_r;

  // One restoring division step: try to take span << BIT_POS from each lane.
  always_comb begin
    divisor  = NUM_BITS'(data_i.span) << BIT_POS;
    data_nxt = data_i;
    for (int k = 0; k < CHANNELS; k++) begin
      if (data_i.rem[k] >= divisor) begin
        data_nxt.rem[k]          = data_i.rem[k] - divisor;
        data_nxt.quo[k][BIT_POS] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.cls <= ctl_i.cls;
    data_r    <= data_nxt;
  end

  assign ctl_o  = ctl_r;
  assign data_o = data_r;

endmodule

`default_nettype wire

// File: hdl/two_color_gradient_map_unit.sv
`default_nettype none

// Two-color gradient map: colors signed samples on a linear RGBA8 ramp.
//
// Input: a sample transfers at a rising edge where start is high and busy is
// low. busy is high only while reset is applied and for the cycle after it;
// otherwise a new sample can be taken in every clock cycle.
// Output: each result shows on out_payload for one cycle with out_strobe
// high, in the same order as the samples. Throughput is one sample per
// cycle, set by the pipeline: a classify stage, a multiply-add stage, eight
// divider cells that each settle one quotient bit, and the output register.
// The receiver cannot stall; results are never held back.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (low level,
// high level, start color, end color) at once. Write only while no sample is
// in flight.
// Reset (synchronous, rst_n low) empties the pipeline and restores the levels
// to 0 and 255, start color to transparent black, end color to opaque white.

module two_color_gradient_map_unit
  import tcgm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  in_payload_t                  in_payload,
  output logic                         out_strobe,
  output out_payload_t                 out_payload,
  input  wire logic                    cfg_we,
  input  wire logic [REG_IDX_BITS-1:0] cfg_index,
  input  wire logic [COLOR_BITS-1:0]   cfg_wdata
);

  logic         busy_r;
  value_t       low_level_r;
  value_t       high_level_r;
  color_t       start_color_r;
  color_t       end_color_r;
  logic         accept;

  cell_ctl_t    chain_ctl  [0:QUO_BITS];
  div_data_t    chain_data [0:QUO_BITS];

  logic         out_strobe_r;
  out_payload_t out_payload_r;
  out_payload_t out_payload_nxt;
  cell_ctl_t    last_ctl;
  div_data_t    last_data;

  // Input is held off only around reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_level_r   <= '0;
      high_level_r  <= VALUE_BITS'(255);
      start_color_r <= '0;
      end_color_r   <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_LEVEL:   low_level_r   <= cfg_wdata[VALUE_BITS-1:0];
        REG_HIGH_LEVEL:  high_level_r  <= cfg_wdata[VALUE_BITS-1:0];
        REG_START_COLOR: start_color_r <= cfg_wdata;
        REG_END_COLOR:   end_color_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify and weight the sample.
  tcgm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_payload  (in_payload),
    .low_level   (low_level_r),
    .high_level  (high_level_r),
    .start_color (start_color_r),
    .end_color   (end_color_r),
    .ctl_o       (chain_ctl[0]),
    .data_o      (chain_data[0])
  );

  // Divider chain, most significant quotient bit first.
  for (genvar j = 0; j < QUO_BITS; j++) begin : g_cell
    tcgm_div_cell #(
      .BIT_POS (QUO_BITS - 1 - j)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (chain_ctl[j]),
      .data_i (chain_data[j]),
      .ctl_o  (chain_ctl[j+1]),
      .data_o (chain_data[j+1])
    );
  end

  assign last_ctl  = chain_ctl[QUO_BITS];
  assign last_data = chain_data[QUO_BITS];

  // Pick the final color by the sample's class.
  always_comb begin
    case (last_ctl.cls)
      CLS_INVALID: begin
        out_payload_nxt.red   = 8'hFF;
        out_payload_nxt.green = 8'hFF;
        out_payload_nxt.blue  = 8'hFF;
        out_payload_nxt.alpha = 8'h00;
      end
      CLS_START: out_payload_nxt = out_payload_t'(start_color_r);
      CLS_END:   out_payload_nxt = out_payload_t'(end_color_r);
      CLS_RAMP: begin
        out_payload_nxt.red   = last_data.quo[0];
        out_payload_nxt.green = last_data.quo[1];
        out_payload_nxt.blue  = last_data.quo[2];
        out_payload_nxt.alpha = last_data.quo[3];
      end
      default: out_payload_nxt = out_payload_t'(end_color_r);
    endcase
  end

  // Output register: one strobe per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= last_ctl.valid;
    end
    out_payload_r <= out_payload_nxt;
  end

  assign out_strobe  = out_strobe_r;
  assign out_payload = out_payload_r;

endmodule

`default_nettype wire

// File: hdl/tcgm_checker.sv
`default_nettype none

module tcgm_checker
  import tcgm_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    start,
  input wire logic                    busy,
  input in_payload_t                  in_payload,
  input wire logic                    out_strobe,
  input out_payload_t                 out_payload
);

  // Input is held off right after a reset cycle.
  a_busy_in_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy not raised after reset");

  // Input can be taken in every cycle once reset is released.
  a_busy_free: assert property (@(posedge clk) rst_n |=> !busy)
    else $error("busy raised outside reset");

  // Every input transfer is followed by a result on out_strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##11 out_strobe)
    else $error("result missing after input transfer");

  // A result appears only for an earlier input transfer.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 11))
    else $error("result without input transfer");

  // A missing sample comes out transparent white.
  a_invalid_white: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_payload.sample_invalid) |-> ##11
      (out_payload.red == 8'hFF && out_payload.green == 8'hFF &&
       out_payload.blue == 8'hFF && out_payload.alpha == 8'h00))
    else $error("invalid sample not mapped to transparent white");

endmodule

bind two_color_gradient_map_unit tcgm_checker u_tcgm_checker (.*);

`default_nettype wire
